// File: src/tsoe_pkg.sv
// types, constants and control program of the slot offset estimator
`timescale 1ns / 1ps

package tsoe_pkg;

    // field and state widths
    localparam int SUM_W       = 44;
    localparam int CNT_W       = 13;
    localparam int DATA_W      = 32;
    localparam int OFFSET_W    = 31;
    localparam int PC_W        = 4;
    localparam int DIV_STEPS   = SUM_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int MAX_SAMPLES = 4096;

    // filter terms divide by 5 (80/100 = 4/5, 20/100 = 1/5) through a reciprocal:
    // (x * RECIP_5) >> RECIP_SHIFT is the exact quotient for any 32-bit x
    localparam logic [31:0] RECIP_5     = 32'hCCCCCCCD;
    localparam int          RECIP_SHIFT = 34;

    localparam logic [31:0] SLOT_LENGTH_RESET = 32'd1000000;

    // register map
    localparam int PADDR_W = 3;
    localparam logic REG_SLOT_LENGTH = 1'b0;

    // input and result items
    typedef struct packed {
        logic                    req_type;
        logic signed [DATA_W-1:0] delay_value;
        logic                    no_reference;
    } item_t;

    typedef struct packed {
        logic signed [OFFSET_W-1:0] offset_value;
        logic [CNT_W-1:0]           samples_used;
    } result_t;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLR_AVG,
        OP_LOAD_SUM,
        OP_DIV_STEP,
        OP_SAVE_AVG,
        OP_LOAD_PREV,
        OP_SAVE_T1,
        OP_LOAD_AVG,
        OP_SAVE_T2,
        OP_SUM,
        OP_CLAMP,
        OP_EMIT,
        OP_EMIT_ZERO
    } op_t;

    // jump conditions
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_NOREF,
        COND_EMPTY,
        COND_DIV_MORE,
        COND_OUT_HOLD
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
        logic            done;
    } ctrl_word_t;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic noref;
        logic empty;
        logic div_more;
        logic out_hold;
    } dp_flags_t;

    // program step addresses
    localparam logic [PC_W-1:0] STEP_START     = 4'd0;
    localparam logic [PC_W-1:0] STEP_DIV_SUM   = 4'd3;
    localparam logic [PC_W-1:0] STEP_LOAD_PREV = 4'd5;
    localparam logic [PC_W-1:0] STEP_EMIT      = 4'd11;
    localparam logic [PC_W-1:0] STEP_EMIT_ZERO = 4'd12;

    localparam ctrl_word_t CTRL_IDLE = '{op: OP_NOP, cond: COND_NEXT,
                                         target: STEP_START, done: 1'b0};

    // control store
    function automatic ctrl_word_t rom_word(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = '{op: OP_NOP, cond: COND_NEXT, target: STEP_START, done: 1'b1};
        case (pc)
            4'd0:  w = '{OP_NOP,       COND_NOREF,    STEP_EMIT_ZERO, 1'b0};
            4'd1:  w = '{OP_CLR_AVG,   COND_EMPTY,    STEP_LOAD_PREV, 1'b0};
            4'd2:  w = '{OP_LOAD_SUM,  COND_NEXT,     STEP_START,     1'b0};
            4'd3:  w = '{OP_DIV_STEP,  COND_DIV_MORE, STEP_DIV_SUM,   1'b0};
            4'd4:  w = '{OP_SAVE_AVG,  COND_NEXT,     STEP_START,     1'b0};
            4'd5:  w = '{OP_LOAD_PREV, COND_NEXT,     STEP_START,     1'b0};
            4'd6:  w = '{OP_SAVE_T1,   COND_NEXT,     STEP_START,     1'b0};
            4'd7:  w = '{OP_LOAD_AVG,  COND_NEXT,     STEP_START,     1'b0};
            4'd8:  w = '{OP_SAVE_T2,   COND_NEXT,     STEP_START,     1'b0};
            4'd9:  w = '{OP_SUM,       COND_NEXT,     STEP_START,     1'b0};
            4'd10: w = '{OP_CLAMP,     COND_NEXT,     STEP_START,     1'b0};
            4'd11: w = '{OP_EMIT,      COND_OUT_HOLD, STEP_EMIT,      1'b1};
            4'd12: w = '{OP_EMIT_ZERO, COND_OUT_HOLD, STEP_EMIT_ZERO, 1'b1};
            default: w = '{OP_NOP,     COND_NEXT,     STEP_START,     1'b1};
        endcase
        return w;
    endfunction

endpackage

// File: src/tdma_slot_offset_estimator_top.sv
// top level of the slot offset estimator: item channels and register port
//
// Delay samples and finish requests arrive as items on the item channel
// (item_valid / item_stall); smoothed offsets leave as items on the result
// channel (result_valid / result_stall). A sample item (req_type 0) is taken
// while item_stall is low and adds to the window unless the window already holds 4096
// samples; it gives no result. A finish item (req_type 1) starts the control
// program, which runs a 44-step serial divider for the average, then one
// reciprocal multiply per filter term, followed by add, clamp and write-out
// steps. An empty window skips the divider and uses a zero average; with
// no_reference set the program writes out a zero result directly.
// item_stall is high while the program runs, so finish items are handled one
// at a time. A result waiting under result_stall holds the result register;
// samples are still taken, and a following finish waits in its last step
// until the register frees. slot_length sits at byte address 0 of the register
// port and may be written only while the block is idle. Reset clears the
// window, the previous offset and the result valid flag and loads slot_length
// with 1000000.
`timescale 1ns / 1ps

module tdma_slot_offset_estimator_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  tsoe_pkg::item_t                item,
    output logic                           result_valid,
    input  logic                           result_stall,
    output tsoe_pkg::result_t              result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tsoe_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import tsoe_pkg::*;

    logic       busy;
    logic       item_fire;
    logic       start;
    logic       sample_en;
    logic [31:0] slot_length_reg;
    ctrl_word_t ctrl;
    dp_flags_t  flags;

    // item handshake
    assign item_stall = busy;
    assign item_fire  = item_valid && !busy;
    assign start      = item_fire && (item.req_type == REQ_FINISH);
    assign sample_en  = item_fire && (item.req_type == REQ_SAMPLE);

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SLOT_LENGTH) ? slot_length_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_length_reg <= SLOT_LENGTH_RESET;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_SLOT_LENGTH)
            slot_length_reg <= pwdata;
    end

    tsoe_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    tsoe_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .sample_en    (sample_en),
        .start_en     (start),
        .item         (item),
        .slot_length  (slot_length_reg),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result),
        .flags        (flags)
    );

endmodule

// File: src/tsoe_seq.sv
// step counter and control store of the finish sequence
`timescale 1ns / 1ps

module tsoe_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  tsoe_pkg::dp_flags_t   flags,
    output tsoe_pkg::ctrl_word_t  ctrl,
    output logic                  busy
);
    import tsoe_pkg::*;

    logic [PC_W-1:0] pc_reg, pc_next;
    logic            busy_reg, busy_next;
    ctrl_word_t      word;
    logic            take;

    assign word = rom_word(pc_reg);
    assign ctrl = busy_reg ? word : CTRL_IDLE;
    assign busy = busy_reg;

    // jump condition
    always_comb
    begin
        case (word.cond)
            COND_NEXT:     take = 1'b0;
            COND_NOREF:    take = flags.noref;
            COND_EMPTY:    take = flags.empty;
            COND_DIV_MORE: take = flags.div_more;
            COND_OUT_HOLD: take = flags.out_hold;
            default:       take = 1'b0;
        endcase
    end

    // next step
    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                pc_next   = STEP_START;
            end
        end
        else if (word.done && !flags.out_hold)
        begin
            busy_next = 1'b0;
            pc_next   = STEP_START;
        end
        else if (take)
        begin
            pc_next = word.target;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= STEP_START;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

    // idle sequencer sits at the first step
    a_idle_pc: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> pc_reg == STEP_START)
        else $error("sequencer idle away from first step");

endmodule

// File: src/tsoe_dp.sv
// window accumulator, serial divider, reciprocal filter, clamp and result register
`timescale 1ns / 1ps

module tsoe_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tsoe_pkg::ctrl_word_t ctrl,
    input  logic                 sample_en,
    input  logic                 start_en,
    input  tsoe_pkg::item_t      item,
    input  logic [31:0]          slot_length,
    input  logic                 result_stall,
    output logic                 result_valid,
    output tsoe_pkg::result_t    result,
    output tsoe_pkg::dp_flags_t  flags
);
    import tsoe_pkg::*;

    // window state
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic signed [DATA_W-1:0] prev_reg, prev_next;
    logic                     noref_reg;

    // working registers
    logic signed [DATA_W-1:0] avg_reg, t1_reg, t2_reg, smooth_reg, res_reg;

    // serial divider
    logic [SUM_W-1:0]     div_q_reg;
    logic [CNT_W-1:0]     div_r_reg;
    logic [CNT_W-1:0]     div_d_reg;
    logic                 div_neg_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    // reciprocal multiplier operand
    logic [DATA_W-1:0]    mul_x_reg;

    // result register
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    logic                     out_hold;
    logic                     fire;
    logic [SUM_W-1:0]         sum_mag;
    logic [DATA_W-1:0]        prev_abs, avg_abs;
    logic [CNT_W:0]           trial;
    logic                     q_bit;
    logic [DATA_W-1:0]        q32;
    logic                     r_nz;
    logic [63:0]              rcp_prod;
    logic [DATA_W-1:0]        rcp_q;
    logic signed [DATA_W-1:0] q_signed;
    logic signed [DATA_W-1:0] limit, neg_limit, clamped;

    assign out_hold = out_valid_reg && result_stall;
    assign fire     = (ctrl.op == OP_EMIT || ctrl.op == OP_EMIT_ZERO) && !out_hold;

    assign flags.noref    = noref_reg;
    assign flags.empty    = (count_reg == '0);
    assign flags.div_more = (div_cnt_reg != DIV_CNT_W'(1));
    assign flags.out_hold = out_hold;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // magnitudes fed into the divider and the multiplier
    assign sum_mag  = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign prev_abs = prev_reg[DATA_W-1] ? (~prev_reg + 1'b1) : prev_reg;
    assign avg_abs  = avg_reg[DATA_W-1] ? (~avg_reg + 1'b1) : avg_reg;

    // one restoring step
    assign trial = {div_r_reg, div_q_reg[SUM_W-1]};
    assign q_bit = (trial >= {1'b0, div_d_reg});

    // average quotient and remainder flag
    assign q32  = div_q_reg[DATA_W-1:0];
    assign r_nz = (div_r_reg != '0);

    // divide by 5 through the reciprocal, truncated toward zero
    assign rcp_prod = 64'(mul_x_reg) * 64'(RECIP_5);
    assign rcp_q    = DATA_W'(rcp_prod[63:RECIP_SHIFT]);
    assign q_signed = div_neg_reg ? (~rcp_q + 1'b1) : rcp_q;

    // clamp to a quarter slot
    assign limit     = {2'b00, slot_length[31:2]};
    assign neg_limit = -limit;
    always_comb
    begin
        if (smooth_reg > 0)
            clamped = (smooth_reg < limit) ? smooth_reg : limit;
        else
            clamped = (smooth_reg > neg_limit) ? smooth_reg : neg_limit;
    end

    // window state update
    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        prev_next  = prev_reg;
        if (sample_en && count_reg < CNT_W'(MAX_SAMPLES))
        begin
            sum_next   = sum_reg + {{(SUM_W-DATA_W){item.delay_value[DATA_W-1]}},
                                    item.delay_value};
            count_next = count_reg + 1'b1;
        end
        if (fire && ctrl.op == OP_EMIT)
        begin
            sum_next   = '0;
            count_next = '0;
            prev_next  = res_reg;
        end
    end

    // result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            count_reg     <= '0;
            prev_reg      <= '0;
            noref_reg     <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
            if (start_en)
                noref_reg <= item.no_reference;
            case (ctrl.op)
                OP_LOAD_SUM:
                    div_cnt_reg <= DIV_CNT_W'(DIV_STEPS);
                OP_DIV_STEP:
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                default:
                    div_cnt_reg <= div_cnt_reg;
            endcase
        end
    end

    // divider, multiplier operand and working registers
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            OP_CLR_AVG:
                avg_reg <= '0;
            OP_LOAD_SUM:
            begin
                div_q_reg   <= sum_mag;
                div_r_reg   <= '0;
                div_d_reg   <= count_reg;
                div_neg_reg <= sum_reg[SUM_W-1];
            end
            OP_LOAD_PREV:
            begin
                // previous offset is clamped below 2^30, so 4 * |prev| fits 32 bits
                mul_x_reg   <= {prev_abs[DATA_W-3:0], 2'b00};
                div_neg_reg <= prev_reg[DATA_W-1];
            end
            OP_LOAD_AVG:
            begin
                mul_x_reg   <= avg_abs;
                div_neg_reg <= avg_reg[DATA_W-1];
            end
            OP_DIV_STEP:
            begin
                div_q_reg <= {div_q_reg[SUM_W-2:0], q_bit};
                div_r_reg <= q_bit ? CNT_W'(trial - {1'b0, div_d_reg}) : trial[CNT_W-1:0];
            end
            OP_SAVE_AVG:
                // floor rounding: a negative sum with a remainder steps down by one
                avg_reg <= div_neg_reg ? (~(q32 + DATA_W'(r_nz)) + 1'b1) : q32;
            OP_SAVE_T1:
                t1_reg <= q_signed;
            OP_SAVE_T2:
                t2_reg <= q_signed;
            OP_SUM:
                smooth_reg <= t1_reg + t2_reg;
            OP_CLAMP:
                res_reg <= clamped;
            default:
                div_q_reg <= div_q_reg;
        endcase
        if (fire)
        begin
            if (ctrl.op == OP_EMIT)
            begin
                out_reg.offset_value <= res_reg[OFFSET_W-1:0];
                out_reg.samples_used <= count_reg;
            end
            else
            begin
                out_reg <= '0;
            end
        end
    end

    // window never grows past capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SAMPLES))
        else $error("sample count above capacity");

    // divider only steps while iterations remain
    a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.op == OP_DIV_STEP |-> div_cnt_reg != '0)
        else $error("divider stepped with no iterations left");

    // emitted offset lies within the clamp window
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && ctrl.op == OP_EMIT) |-> (res_reg <= limit && res_reg >= neg_limit))
        else $error("offset outside clamp window");

endmodule
